[design/slcd_pkg.sv]
// Shared types and constants for the sync, length and checksum deframer.
`timescale 1ns / 1ps
`default_nettype none

package slcd_pkg;

  // Classification of one received byte by the front parser.
  typedef enum logic [2:0] {
    KIND_DROP,
    KIND_SYNC1,
    KIND_SYNC2,
    KIND_DEVICE,
    KIND_LENGTH,
    KIND_PAYLOAD,
    KIND_CHECK
  } kind_t;

  // One classified byte as it travels from the front part to the back part.
  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic [7:0] index;
  } entry_t;

  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_PAYLOAD = 2'd1;
  localparam logic [1:0] EV_ACCEPT  = 2'd2;
  localparam logic [1:0] EV_BAD_SUM = 2'd3;

  localparam logic [7:0] REG_SYNC_FIRST  = 8'd0;
  localparam logic [7:0] REG_SYNC_SECOND = 8'd1;

  localparam logic [7:0] SYNC_FIRST_RESET  = 8'd85;
  localparam logic [7:0] SYNC_SECOND_RESET = 8'd170;

  localparam logic [8:0] POS_HUNT   = 9'd0;
  localparam logic [8:0] POS_SYNC2  = 9'd1;
  localparam logic [8:0] POS_DEVICE = 9'd2;
  localparam logic [8:0] POS_LENGTH = 9'd3;
  localparam logic [8:0] POS_BODY   = 9'd4;

endpackage

`default_nettype wire

[design/slcd_front.sv]
// Front parser: accepts received bytes, tracks the frame position and classifies each byte.
`timescale 1ns / 1ps
`default_nettype none

module slcd_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [7:0]      rx_byte,
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic [7:0]      cfg_index,
  input  wire logic [7:0]      cfg_data,
  input  wire logic            queue_full,
  output logic                 push,
  output slcd_pkg::entry_t     push_entry
);

  logic [7:0] sync_first;
  logic [7:0] sync_second;
  logic [8:0] position;
  logic [8:0] position_next;
  logic [7:0] length;
  logic [8:0] body_offset;

  assign in_ready  = !queue_full;
  assign cfg_ready = 1'b1;
  assign push      = in_valid && in_ready;

  assign body_offset = position - slcd_pkg::POS_BODY;

  always_comb begin
    position_next    = position;
    push_entry.kind  = slcd_pkg::KIND_DROP;
    push_entry.data  = rx_byte;
    push_entry.index = body_offset[7:0];
    case (position)
      slcd_pkg::POS_HUNT: begin
        if (rx_byte == sync_first) begin
          push_entry.kind = slcd_pkg::KIND_SYNC1;
          position_next   = slcd_pkg::POS_SYNC2;
        end
      end
      slcd_pkg::POS_SYNC2: begin
        // A mismatching second sync byte is not retried as a first sync byte.
        if (rx_byte == sync_second) begin
          push_entry.kind = slcd_pkg::KIND_SYNC2;
          position_next   = slcd_pkg::POS_DEVICE;
        end else begin
          position_next = slcd_pkg::POS_HUNT;
        end
      end
      slcd_pkg::POS_DEVICE: begin
        push_entry.kind = slcd_pkg::KIND_DEVICE;
        position_next   = slcd_pkg::POS_LENGTH;
      end
      slcd_pkg::POS_LENGTH: begin
        push_entry.kind = slcd_pkg::KIND_LENGTH;
        position_next   = slcd_pkg::POS_BODY;
      end
      default: begin
        if (body_offset < {1'b0, length}) begin
          push_entry.kind = slcd_pkg::KIND_PAYLOAD;
          position_next   = position + 9'd1;
        end else begin
          push_entry.kind = slcd_pkg::KIND_CHECK;
          position_next   = slcd_pkg::POS_HUNT;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first  <= slcd_pkg::SYNC_FIRST_RESET;
      sync_second <= slcd_pkg::SYNC_SECOND_RESET;
      position    <= slcd_pkg::POS_HUNT;
      length      <= 8'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == slcd_pkg::REG_SYNC_FIRST) begin
          sync_first <= cfg_data;
        end else if (cfg_index == slcd_pkg::REG_SYNC_SECOND) begin
          sync_second <= cfg_data;
        end
      end
      if (push) begin
        position <= position_next;
        if (position == slcd_pkg::POS_LENGTH) begin
          length <= rx_byte;
        end
      end
    end
  end

endmodule

`default_nettype wire

[design/slcd_queue.sv]
// Short queue of classified bytes between the front parser and the back end.
`timescale 1ns / 1ps
`default_nettype none

module slcd_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire slcd_pkg::entry_t push_entry,
  output logic                  full,
  input  wire logic             pop,
  output logic                  not_empty,
  output slcd_pkg::entry_t      head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  slcd_pkg::entry_t slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full      = (count == FULL_COUNT);
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[design/slcd_back.sv]
// Back end: keeps the running checksum and frame registers and drives the result register.
`timescale 1ns / 1ps
`default_nettype none

module slcd_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             not_empty,
  input  wire slcd_pkg::entry_t head,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [1:0]            event_res,
  output logic [7:0]            payload_index,
  output logic [7:0]            payload_byte,
  output logic [7:0]            frame_device,
  output logic [7:0]            frame_length
);

  logic [7:0] running_sum;
  logic [7:0] running_sum_next;
  logic [7:0] device_next;
  logic [7:0] length_next;
  logic [1:0] event_next;
  logic [7:0] index_next;
  logic [7:0] byte_next;

  // The result register takes a new request whenever it is empty or being drained.
  assign pop = not_empty && (!out_valid || out_ready);

  always_comb begin
    running_sum_next = running_sum;
    device_next      = frame_device;
    length_next      = frame_length;
    event_next       = slcd_pkg::EV_NONE;
    index_next       = 8'd0;
    byte_next        = 8'd0;
    case (head.kind)
      slcd_pkg::KIND_DROP: begin
      end
      slcd_pkg::KIND_SYNC1: begin
        running_sum_next = head.data;
      end
      slcd_pkg::KIND_SYNC2: begin
        running_sum_next = running_sum + head.data;
      end
      slcd_pkg::KIND_DEVICE: begin
        running_sum_next = running_sum + head.data;
        device_next      = head.data;
      end
      slcd_pkg::KIND_LENGTH: begin
        running_sum_next = running_sum + head.data;
        length_next      = head.data;
      end
      slcd_pkg::KIND_PAYLOAD: begin
        running_sum_next = running_sum + head.data;
        event_next       = slcd_pkg::EV_PAYLOAD;
        index_next       = head.index;
        byte_next        = head.data;
      end
      slcd_pkg::KIND_CHECK: begin
        event_next = (running_sum == head.data) ? slcd_pkg::EV_ACCEPT
                                                : slcd_pkg::EV_BAD_SUM;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      running_sum   <= 8'd0;
      frame_device  <= 8'd0;
      frame_length  <= 8'd0;
      event_res     <= slcd_pkg::EV_NONE;
      payload_index <= 8'd0;
      payload_byte  <= 8'd0;
    end else begin
      if (pop) begin
        out_valid     <= 1'b1;
        running_sum   <= running_sum_next;
        frame_device  <= device_next;
        frame_length  <= length_next;
        event_res     <= event_next;
        payload_index <= index_next;
        payload_byte  <= byte_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[design/sync_length_checksum_deframer_core.sv]
// Top level of the sync, length and checksum frame parser.
//
// The block takes one received byte per request and gives exactly one result per byte:
// nothing, a payload byte with its index, frame accepted, or checksum error, together
// with the device id and length of the current or last frame. Frames are two sync bytes
// (set through configuration registers 0 and 1), a device id, a length, that many payload
// bytes and an 8-bit additive checksum over everything before it. It sustains one byte
// per clock cycle while results are taken and drops in_ready when the queue is full. The
// front parser classifies each byte and writes it into the queue when it is accepted, and
// the back end moves it into the result register when that register is free. The queue
// of QUEUE_DEPTH entries lets the input keep flowing while a result waits to be taken.
`timescale 1ns / 1ps
`default_nettype none

module sync_length_checksum_deframer_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  rx_byte,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       event_res,
  output logic [7:0]       payload_index,
  output logic [7:0]       payload_byte,
  output logic [7:0]       frame_device,
  output logic [7:0]       frame_length
);

  logic             push;
  slcd_pkg::entry_t push_entry;
  logic             queue_full;
  logic             pop;
  logic             not_empty;
  slcd_pkg::entry_t head;

  slcd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .queue_full (queue_full),
    .push       (push),
    .push_entry (push_entry)
  );

  slcd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .not_empty  (not_empty),
    .head       (head)
  );

  slcd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .not_empty     (not_empty),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .event_res     (event_res),
    .payload_index (payload_index),
    .payload_byte  (payload_byte),
    .frame_device  (frame_device),
    .frame_length  (frame_length)
  );

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
// Self-checking testbench for the sync, length and checksum frame parser.
`timescale 1ns / 1ps

module testbench;

  localparam int IDLE_LIMIT = 3000;

  typedef struct packed {
    logic [1:0] ev;
    logic [7:0] idx;
    logic [7:0] pb;
    logic [7:0] dev;
    logic [7:0] len;
  } parse_result_t;

  // Tracks the parser state for every accepted byte and holds the results still due.
  class deframe_tracker;
    logic [7:0] sync_a;
    logic [7:0] sync_b;
    logic [8:0] pos;
    logic [7:0] dev;
    logic [7:0] len;
    logic [7:0] run_sum;
    parse_result_t due_results[$];
    int unsigned errors;

    function new();
      sync_a  = slcd_pkg::SYNC_FIRST_RESET;
      sync_b  = slcd_pkg::SYNC_SECOND_RESET;
      pos     = slcd_pkg::POS_HUNT;
      dev     = '0;
      len     = '0;
      run_sum = '0;
      errors  = 0;
    endfunction

    function void write_reg(logic [7:0] index, logic [7:0] value);
      if (index == slcd_pkg::REG_SYNC_FIRST) begin
        sync_a = value;
      end else if (index == slcd_pkg::REG_SYNC_SECOND) begin
        sync_b = value;
      end
    endfunction

    function void note_byte(logic [7:0] b);
      parse_result_t r;
      logic [8:0] k;
      r = '0;
      case (pos)
        slcd_pkg::POS_HUNT: begin
          if (b == sync_a) begin
            run_sum = b;
            pos = slcd_pkg::POS_SYNC2;
          end
        end
        slcd_pkg::POS_SYNC2: begin
          // A mismatching second sync byte is dropped, even if it equals the first sync.
          if (b == sync_b) begin
            run_sum = run_sum + b;
            pos = slcd_pkg::POS_DEVICE;
          end else begin
            pos = slcd_pkg::POS_HUNT;
          end
        end
        slcd_pkg::POS_DEVICE: begin
          dev = b;
          run_sum = run_sum + b;
          pos = slcd_pkg::POS_LENGTH;
        end
        slcd_pkg::POS_LENGTH: begin
          len = b;
          run_sum = run_sum + b;
          pos = slcd_pkg::POS_BODY;
        end
        default: begin
          k = pos - slcd_pkg::POS_BODY;
          if (k < {1'b0, len}) begin
            r.ev  = slcd_pkg::EV_PAYLOAD;
            r.idx = k[7:0];
            r.pb  = b;
            run_sum = run_sum + b;
            pos = pos + 9'd1;
          end else begin
            r.ev = (run_sum == b) ? slcd_pkg::EV_ACCEPT : slcd_pkg::EV_BAD_SUM;
            pos = slcd_pkg::POS_HUNT;
          end
        end
      endcase
      r.dev = dev;
      r.len = len;
      due_results.push_back(r);
    endfunction

    function int unsigned pending();
      return due_results.size();
    endfunction

    function void field_check(string name, int want, int got);
      if (want != got) begin
        $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(parse_result_t got);
      parse_result_t want;
      if (due_results.size() == 0) begin
        $display("%0t: result with none expected, actual event %0d", $time, got.ev);
        errors++;
        return;
      end
      want = due_results.pop_front();
      field_check("event_res", want.ev, got.ev);
      field_check("payload_index", want.idx, got.idx);
      field_check("payload_byte", want.pb, got.pb);
      field_check("frame_device", want.dev, got.dev);
      field_check("frame_length", want.len, got.len);
    endfunction
  endclass

  logic       clk;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] rx_byte = '0;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] event_res;
  logic [7:0] payload_index;
  logic [7:0] payload_byte;
  logic [7:0] frame_device;
  logic [7:0] frame_length;

  deframe_tracker tracker;
  logic [7:0] frame_q[$];
  bit quiet = 1'b0;
  int out_stall = 0;
  int idle_cycles = 0;

  sync_length_checksum_deframer_core i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .rx_byte(rx_byte),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .event_res(event_res),
    .payload_index(payload_index),
    .payload_byte(payload_byte),
    .frame_device(frame_device),
    .frame_length(frame_length)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  always @(posedge clk) begin
    parse_result_t got;
    int n;
    if (rst) begin
      out_ready <= 1'b0;
      out_stall <= 0;
    end else begin
      if (out_valid && out_ready) begin
        got.ev  = event_res;
        got.idx = payload_index;
        got.pb  = payload_byte;
        got.dev = frame_device;
        got.len = frame_length;
        tracker.check_result(got);
      end
      if (out_stall != 0) begin
        out_stall <= out_stall - 1;
        out_ready <= 1'b0;
      end else begin
        n = pick_gap();
        if (n == 0) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          out_stall <= n - 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // The valid stays high after a request with no gap, so the next byte follows at once.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    tracker.note_byte(b);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_range(input int first, input int last);
    for (int i = first; i <= last; i++) send_byte(frame_q[i]);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [7:0] index, input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    tracker.write_reg(index, value);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic start_frame(input logic [7:0] s1, input logic [7:0] s2,
                             input logic [7:0] dev, input logic [7:0] len);
    frame_q.delete();
    frame_q.push_back(s1);
    frame_q.push_back(s2);
    frame_q.push_back(dev);
    frame_q.push_back(len);
  endtask

  task automatic close_frame(input bit good);
    logic [7:0] s;
    s = '0;
    foreach (frame_q[i]) s = s + frame_q[i];
    if (!good) s = s + 8'($urandom_range(1, 255));
    frame_q.push_back(s);
  endtask

  task automatic random_frame(input int len, input bit good);
    start_frame(tracker.sync_a, tracker.sync_b, 8'($urandom_range(0, 255)), 8'(len));
    repeat (len) frame_q.push_back(8'($urandom_range(0, 255)));
    close_frame(good);
  endtask

  task automatic run_directed();
    // Second sync mismatch on a copy of the first sync, then a stray second sync.
    frame_q = '{slcd_pkg::SYNC_FIRST_RESET, slcd_pkg::SYNC_FIRST_RESET,
                slcd_pkg::SYNC_SECOND_RESET};
    send_range(0, 2);
    // Zero length frame: the byte after the length is the checksum.
    start_frame(slcd_pkg::SYNC_FIRST_RESET, slcd_pkg::SYNC_SECOND_RESET, 8'hFF, 8'd0);
    close_frame(1'b1);
    send_range(0, frame_q.size() - 1);
    start_frame(slcd_pkg::SYNC_FIRST_RESET, slcd_pkg::SYNC_SECOND_RESET, 8'h5A, 8'd2);
    frame_q.push_back(8'h00);
    frame_q.push_back(8'hFF);
    close_frame(1'b0);
    send_range(0, frame_q.size() - 1);
    start_frame(slcd_pkg::SYNC_FIRST_RESET, slcd_pkg::SYNC_SECOND_RESET, 8'h00, 8'd1);
    frame_q.push_back(8'hA5);
    close_frame(1'b1);
    send_range(0, frame_q.size() - 1);
    // A sync register changes while a frame is half received.
    start_frame(slcd_pkg::SYNC_FIRST_RESET, slcd_pkg::SYNC_SECOND_RESET, 8'h3C, 8'd1);
    frame_q.push_back(8'h80);
    close_frame(1'b1);
    send_range(0, 2);
    settle();
    write_reg(slcd_pkg::REG_SYNC_SECOND, 8'h3C);
    send_range(3, frame_q.size() - 1);
  endtask

  task automatic run_random(input int n_items);
    int done;
    int r;
    int len;
    logic [7:0] b;
    done = 0;
    while (done < n_items) begin
      r = $urandom_range(0, 99);
      len = ($urandom_range(0, 99) < 92) ? $urandom_range(0, 6) : $urandom_range(7, 40);
      if (r < 8) begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
      end else if (r < 13) begin
        if ($urandom_range(0, 1) == 1 && tracker.sync_a != tracker.sync_b) begin
          b = tracker.sync_a;
        end else begin
          do b = 8'($urandom_range(0, 255)); while (b == tracker.sync_b);
        end
        frame_q = '{tracker.sync_a, b};
        send_range(0, 1);
        done += 2;
      end else if (r < 18) begin
        random_frame(len, 1'b1);
        len = $urandom_range(1, frame_q.size() - 1);
        send_range(0, len - 1);
        done += len;
      end else if (r < 20) begin
        settle();
      end else begin
        random_frame(len, $urandom_range(0, 99) < 80);
        send_range(0, frame_q.size() - 1);
        done += frame_q.size();
      end
    end
  endtask

  initial begin
    logic [7:0] sa;
    logic [7:0] sb;
    tracker = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    run_random(64);
    settle();
    for (int p = 1; p <= 5; p++) begin
      case (p)
        1: begin sa = 8'h00; sb = 8'hFF; end
        2: begin sa = 8'hFF; sb = 8'h00; end
        3: begin sa = 8'($urandom_range(0, 255)); sb = sa; end
        4: begin sa = 8'($urandom_range(0, 255)); sb = 8'($urandom_range(0, 255)); end
        default: begin sa = slcd_pkg::SYNC_FIRST_RESET; sb = slcd_pkg::SYNC_SECOND_RESET; end
      endcase
      if ($urandom_range(0, 1) == 1) begin
        write_reg(slcd_pkg::REG_SYNC_FIRST, sa);
        write_reg(slcd_pkg::REG_SYNC_SECOND, sb);
      end else begin
        write_reg(slcd_pkg::REG_SYNC_SECOND, sb);
        write_reg(slcd_pkg::REG_SYNC_FIRST, sa);
      end
      quiet = (p == 2);
      if (p == 1) begin
        // The longest payload drives the position counter past 255.
        random_frame(255, 1'b1);
        send_range(0, frame_q.size() - 1);
      end
      run_random(64);
      settle();
    end
    quiet = 1'b0;
    settle();
    repeat (10) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[sim.f]
design/slcd_pkg.sv
design/slcd_front.sv
design/slcd_queue.sv
design/slcd_back.sv
design/sync_length_checksum_deframer_core.sv
tb/sv/testbench.sv
